### rtl/core/tsca_pkg.sv
// tsca_pkg: widths, register indexes, reset values and divider request and response types
// for the touch sample calibrate and average block
// no dependencies
`default_nettype none

package tsca_pkg;

    // field widths
    localparam int RAW_W  = 15;             // raw converter words
    localparam int THR_W  = 13;             // pressure and its threshold
    localparam int CAL_W  = 11;             // shifted raw position and bounds
    localparam int SIZE_W = 12;             // screen size
    localparam int POS_W  = 12;             // screen position
    localparam int ORI_W  = 3;              // orientation flags
    localparam int DVD_W  = CAL_W + SIZE_W; // product of offset and screen size

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = THR_W;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_LOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENT    = 3'd7;

    // register reset values
    localparam logic [THR_W-1:0]  RST_THRESHOLD = 13'd400;
    localparam logic [CAL_W-1:0]  RST_X_LOW     = 11'd200;
    localparam logic [CAL_W-1:0]  RST_X_HIGH    = 11'd1950;
    localparam logic [CAL_W-1:0]  RST_Y_LOW     = 11'd200;
    localparam logic [CAL_W-1:0]  RST_Y_HIGH    = 11'd1860;
    localparam logic [SIZE_W-1:0] RST_WIDTH     = 12'd320;
    localparam logic [SIZE_W-1:0] RST_HEIGHT    = 12'd240;
    localparam logic [ORI_W-1:0]  RST_ORIENT    = 3'd0;

    // pressure offset added before subtracting the second reading
    localparam logic [THR_W-1:0] PRESS_OFFSET = 13'd4096;

    // orientation flag bits
    localparam int ORI_SWAP  = 0;
    localparam int ORI_INV_X = 1;
    localparam int ORI_INV_Y = 2;

    localparam int AVG_DEPTH_DEF = 4;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [CAL_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

### rtl/core/touch_sample_calibrate_average_top.sv
// touch sample calibrate average: a touch maps both axes and averages them with the
// last n points (n = history entries averaged, 1..AVG_DEPTH) into the held position
// the shared serial divider runs four divisions per touch, of DVD_W (23) bits each
// an untouched sample skips the divider; one request at a time, ready only when idle
// synchronous active-low reset loads the register defaults, clears the average count
// and the held position; the position history holds whatever it had until written
`default_nettype none

module touch_sample_calibrate_average_top #(
    parameter int AVG_DEPTH = tsca_pkg::AVG_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic [tsca_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [tsca_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // sample request
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // z1_word [14:0], z2_word [29:15], x_word [44:30], y_word [59:45], zero pad [63:60]
    input  wire logic [63:0]                        s_tdata,
    // result
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // pos_x [11:0], pos_y [23:12]
    output logic [23:0]                             m_tdata,
    // touched [0]
    output logic                                    m_tuser
);

    localparam int RAW_W  = tsca_pkg::RAW_W;
    localparam int THR_W  = tsca_pkg::THR_W;
    localparam int CAL_W  = tsca_pkg::CAL_W;
    localparam int SIZE_W = tsca_pkg::SIZE_W;
    localparam int POS_W  = tsca_pkg::POS_W;
    localparam int ORI_W  = tsca_pkg::ORI_W;
    localparam int DVD_W  = tsca_pkg::DVD_W;

    // history sizing follows the averaging depth
    localparam int CNT_W = $clog2(AVG_DEPTH + 1);
    localparam int IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W = POS_W + $clog2(AVG_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(AVG_DEPTH);
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;  // waiting for a request
    localparam logic [3:0] S_MAP   = 4'd1;  // offset times size, start divide by span
    localparam logic [3:0] S_DIV   = 4'd2;  // wait for scaled axis, saturate, invert
    localparam logic [3:0] S_SHIFT = 4'd3;  // push new point into history
    localparam logic [3:0] S_SUM   = 4'd4;  // accumulate one history entry per cycle
    localparam logic [3:0] S_AVG   = 4'd5;  // start divide of sum by count
    localparam logic [3:0] S_AVGW  = 4'd6;  // wait for average, update held position
    localparam logic [3:0] S_DONE  = 4'd7;  // load result register

    // configuration registers
    logic [THR_W-1:0]  r_thr;
    logic [CAL_W-1:0]  r_x_lo, r_x_hi, r_y_lo, r_y_hi;
    logic [SIZE_W-1:0] r_width, r_height;
    logic [ORI_W-1:0]  r_orient;

    // control
    logic [3:0]       r_state, n_state;
    logic             r_axis, n_axis;          // 0 works on x, 1 on y
    logic [CNT_W-1:0] r_hist_cnt, n_hist_cnt;
    logic [CNT_W-1:0] r_sum_idx, n_sum_idx;
    logic [POS_W-1:0] r_held_x, n_held_x;
    logic [POS_W-1:0] r_held_y, n_held_y;
    logic             r_out_valid, n_out_valid;

    // payload
    logic [CAL_W-1:0] r_rx, n_rx;
    logic [CAL_W-1:0] r_ry, n_ry;
    logic             r_touch, n_touch;
    logic [POS_W-1:0] r_px, n_px;
    logic [POS_W-1:0] r_py, n_py;
    logic [SUM_W-1:0] r_sum_x, n_sum_x;
    logic [SUM_W-1:0] r_sum_y, n_sum_y;
    logic [POS_W-1:0] r_out_x, n_out_x;
    logic [POS_W-1:0] r_out_y, n_out_y;
    logic             r_out_touch, n_out_touch;
    logic [POS_W-1:0] r_hist_x [AVG_DEPTH];
    logic [POS_W-1:0] r_hist_y [AVG_DEPTH];

    // request decode
    logic             w_acc;
    logic [RAW_W-1:0] w_z1, w_z2, w_xw, w_yw;
    logic [THR_W-1:0] w_press;
    logic             w_touch;

    // axis mapping datapath
    logic [CAL_W-1:0]  w_raw, w_lo, w_hi, w_off, w_span;
    logic [SIZE_W-1:0] w_size;
    logic [DVD_W-1:0]  w_prod;
    logic              w_inv;
    logic [POS_W-1:0]  w_sat, w_mapped;
    logic              w_last_sum;
    logic [CNT_W-1:0]  w_idx_inc;

    tsca_pkg::t_div_req w_div_req;
    tsca_pkg::t_div_rsp w_div_rsp;

    assign s_tready = (r_state == S_IDLE);
    assign w_acc    = s_tvalid && s_tready;

    assign w_z1 = s_tdata[14:0];
    assign w_z2 = s_tdata[29:15];
    assign w_xw = s_tdata[44:30];
    assign w_yw = s_tdata[59:45];

    // pressure stays within 1..8191, no wrap possible
    assign w_press = {1'b0, w_z1[RAW_W-1:3]} + tsca_pkg::PRESS_OFFSET
                   - {1'b0, w_z2[RAW_W-1:3]};
    assign w_touch = (w_press > r_thr);

    // config writes; the user must issue them only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= tsca_pkg::RST_THRESHOLD;
            r_x_lo   <= tsca_pkg::RST_X_LOW;
            r_x_hi   <= tsca_pkg::RST_X_HIGH;
            r_y_lo   <= tsca_pkg::RST_Y_LOW;
            r_y_hi   <= tsca_pkg::RST_Y_HIGH;
            r_width  <= tsca_pkg::RST_WIDTH;
            r_height <= tsca_pkg::RST_HEIGHT;
            r_orient <= tsca_pkg::RST_ORIENT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tsca_pkg::CFG_THRESHOLD: r_thr    <= i_cfg_data[THR_W-1:0];
                tsca_pkg::CFG_X_LOW:     r_x_lo   <= i_cfg_data[CAL_W-1:0];
                tsca_pkg::CFG_X_HIGH:    r_x_hi   <= i_cfg_data[CAL_W-1:0];
                tsca_pkg::CFG_Y_LOW:     r_y_lo   <= i_cfg_data[CAL_W-1:0];
                tsca_pkg::CFG_Y_HIGH:    r_y_hi   <= i_cfg_data[CAL_W-1:0];
                tsca_pkg::CFG_WIDTH:     r_width  <= i_cfg_data[SIZE_W-1:0];
                tsca_pkg::CFG_HEIGHT:    r_height <= i_cfg_data[SIZE_W-1:0];
                tsca_pkg::CFG_ORIENT:    r_orient <= i_cfg_data[ORI_W-1:0];
                default: ;
            endcase
        end
    end

    // per-axis operands; after a swap the x calibration applies to the former y
    assign w_raw  = r_axis ? r_ry     : r_rx;
    assign w_lo   = r_axis ? r_y_lo   : r_x_lo;
    assign w_hi   = r_axis ? r_y_hi   : r_x_hi;
    assign w_size = r_axis ? r_height : r_width;
    assign w_inv  = r_axis ? r_orient[tsca_pkg::ORI_INV_Y] : r_orient[tsca_pkg::ORI_INV_X];

    // offset clamps at zero, a span that is not positive counts as one
    assign w_off  = (w_raw > w_lo) ? (w_raw - w_lo) : '0;
    assign w_span = (w_hi > w_lo) ? (w_hi - w_lo) : CAL_W'(1);
    assign w_prod = DVD_W'(w_off) * DVD_W'(w_size);

    // scaled value saturates, inversion clamps at zero (size never exceeds the max)
    assign w_sat    = (w_div_rsp.quot > DVD_W'(POS_MAX)) ? POS_MAX
                                                         : w_div_rsp.quot[POS_W-1:0];
    assign w_mapped = !w_inv ? w_sat : ((w_size > w_sat) ? (w_size - w_sat) : '0);

    assign w_idx_inc  = r_sum_idx + CNT_W'(1);
    assign w_last_sum = (w_idx_inc == r_hist_cnt);

    // the divider is shared by both axis scalings and both averages
    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.dividend = w_prod;
        w_div_req.divisor  = w_span;
        if (r_state == S_MAP) begin
            w_div_req.start = 1'b1;
        end else if (r_state == S_AVG) begin
            w_div_req.start    = 1'b1;
            w_div_req.dividend = r_axis ? DVD_W'(r_sum_y) : DVD_W'(r_sum_x);
            w_div_req.divisor  = CAL_W'(r_hist_cnt);
        end
    end

    tsca_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_hist_cnt  = r_hist_cnt;
        n_sum_idx   = r_sum_idx;
        n_held_x    = r_held_x;
        n_held_y    = r_held_y;
        n_out_valid = r_out_valid;
        n_rx        = r_rx;
        n_ry        = r_ry;
        n_touch     = r_touch;
        n_px        = r_px;
        n_py        = r_py;
        n_sum_x     = r_sum_x;
        n_sum_y     = r_sum_y;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_touch = r_out_touch;

        if (r_out_valid && m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_touch = w_touch;
                    n_axis  = 1'b0;
                    if (r_orient[tsca_pkg::ORI_SWAP]) begin
                        n_rx = w_yw[RAW_W-1:4];
                        n_ry = w_xw[RAW_W-1:4];
                    end else begin
                        n_rx = w_xw[RAW_W-1:4];
                        n_ry = w_yw[RAW_W-1:4];
                    end
                    if (w_touch) begin
                        n_state = S_MAP;
                    end else begin
                        // no touch: restart averaging, keep the held position
                        n_hist_cnt = '0;
                        n_state    = S_DONE;
                    end
                end
            end
            S_MAP: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    if (!r_axis) begin
                        n_px    = w_mapped;
                        n_axis  = 1'b1;
                        n_state = S_MAP;
                    end else begin
                        n_py    = w_mapped;
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                if (r_hist_cnt < DEPTH_C) begin
                    n_hist_cnt = r_hist_cnt + CNT_W'(1);
                end
                n_sum_idx = '0;
                n_sum_x   = '0;
                n_sum_y   = '0;
                n_state   = S_SUM;
            end
            S_SUM: begin
                n_sum_x   = r_sum_x + SUM_W'(r_hist_x[r_sum_idx[IDX_W-1:0]]);
                n_sum_y   = r_sum_y + SUM_W'(r_hist_y[r_sum_idx[IDX_W-1:0]]);
                n_sum_idx = w_idx_inc;
                if (w_last_sum) begin
                    n_axis  = 1'b0;
                    n_state = S_AVG;
                end
            end
            S_AVG: begin
                n_state = S_AVGW;
            end
            S_AVGW: begin
                if (w_div_rsp.done) begin
                    if (!r_axis) begin
                        n_held_x = w_div_rsp.quot[POS_W-1:0];
                        n_axis   = 1'b1;
                        n_state  = S_AVG;
                    end else begin
                        n_held_y = w_div_rsp.quot[POS_W-1:0];
                        n_state  = S_DONE;
                    end
                end
            end
            S_DONE: begin
                // result register frees up when the previous result is taken
                if (!r_out_valid || m_tready) begin
                    n_out_touch = r_touch;
                    n_out_x     = r_held_x;
                    n_out_y     = r_held_y;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_hist_cnt  <= '0;
            r_sum_idx   <= '0;
            r_held_x    <= '0;
            r_held_y    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_hist_cnt  <= n_hist_cnt;
            r_sum_idx   <= n_sum_idx;
            r_held_x    <= n_held_x;
            r_held_y    <= n_held_y;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx        <= n_rx;
        r_ry        <= n_ry;
        r_touch     <= n_touch;
        r_px        <= n_px;
        r_py        <= n_py;
        r_sum_x     <= n_sum_x;
        r_sum_y     <= n_sum_y;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_touch <= n_out_touch;
    end

    // history line, newest entry first
    always_ff @(posedge i_clk) begin
        if (r_state == S_SHIFT) begin
            for (int i = AVG_DEPTH - 1; i > 0; i--) begin
                r_hist_x[i] <= r_hist_x[i-1];
                r_hist_y[i] <= r_hist_y[i-1];
            end
            r_hist_x[0] <= r_px;
            r_hist_y[0] <= r_py;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {r_out_y, r_out_x};
    assign m_tuser  = r_out_touch;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hist_cnt <= DEPTH_C)
        else $error("history count above averaging depth");

    a_no_touch_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_touch) |=> (r_state == S_DONE && r_hist_cnt == '0))
        else $error("untouched sample did not clear the average count");

    a_sum_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> (r_sum_idx < r_hist_cnt && r_hist_cnt != '0))
        else $error("summing past the valid history");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside the done step");

endmodule

`default_nettype wire

### rtl/core/tsca_div.sv
// tsca_div: restoring divider, one quotient bit per cycle
// uses tsca_pkg for widths and the request and response structs
`default_nettype none

module tsca_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tsca_pkg::t_div_req i_req,
    output tsca_pkg::t_div_rsp     o_rsp
);

    localparam int DVD_W = tsca_pkg::DVD_W;
    localparam int DVS_W = tsca_pkg::CAL_W;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVD_W-1:0] r_q, n_q;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs, n_dvs;

    logic [DVS_W:0] w_sh;
    logic [DVS_W:0] w_diff;
    logic           w_ge;

    assign w_sh   = {r_rem, r_q[DVD_W-1]};
    assign w_ge   = (w_sh >= {1'b0, r_dvs});
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DVD_W);
            n_q    = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so the difference fits
            n_rem = w_ge ? w_diff[DVS_W-1:0] : w_sh[DVS_W-1:0];
            n_q   = {r_q[DVD_W-2:0], w_ge};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

    // a new division only starts once the previous one has finished
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (i_req.divisor != '0))
        else $error("divider started with zero divisor");

endmodule

`default_nettype wire
